[rtl/swmsd_pkg.sv]
// Package: sizes, derived widths and control states of the sliding-window mean/std block.
package swmsd_pkg;

   localparam int WINDOW      = 16;
   localparam int SAMPLE_BITS = 16;

   localparam int SAMPLE_W = 16;
   localparam int MEAN_W   = 20;
   localparam int STD_W    = 19;

   localparam int LOG2N     = $clog2(WINDOW);
   localparam int KEEP_W    = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int SUM_W     = KEEP_W + LOG2N;
   localparam int SQ_W      = 2 * KEEP_W + LOG2N;
   localparam int PROD_W    = 2 * SUM_W;
   localparam int DEV_W     = SQ_W + LOG2N;
   localparam int RAD_W     = DEV_W + 8;
   localparam int ROOT_W    = RAD_W / 2;
   localparam int MUL_STEPS = (SUM_W + 1) / 2;
   localparam int MUL_B_W   = 2 * MUL_STEPS;
   localparam int MUL_CNT_W = $clog2(MUL_STEPS);
   localparam int ROOT_CNT_W = $clog2(ROOT_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_QUPD,
      ST_DEV,
      ST_ROOT,
      ST_DONE
   } state_type;

endpackage

[rtl/swmsd_req_if.sv]
// Interface: sample channel, valid/ready handshake.
interface swmsd_req_if;
   logic                          valid;
   logic                          ready;
   logic [swmsd_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

[rtl/swmsd_rsp_if.sv]
// Interface: result channel carrying window mean and standard deviation.
interface swmsd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [swmsd_pkg::MEAN_W-1:0] window_mean;
   logic [swmsd_pkg::STD_W-1:0]  window_std;

   modport source (output valid, output window_mean, output window_std, input ready);
   modport sink   (input valid, input window_mean, input window_std, output ready);
endinterface

[rtl/swmsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module swmsd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/swmsd_mul.sv]
// Radix-4 serial shift-add multiplier, two multiplier bits per cycle.
module swmsd_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [swmsd_pkg::SUM_W-1:0]  a,
   input  logic [swmsd_pkg::SUM_W-1:0]  b,
   output logic                         done,
   output logic [swmsd_pkg::PROD_W-1:0] product
);
   import swmsd_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]     a_ff, a_in;
   logic [SUM_W+1:0]     a3_ff, a3_in;
   logic [SUM_W-1:0]     hi_ff, hi_in;
   logic [MUL_B_W-1:0]   lo_ff, lo_in;
   logic [SUM_W+1:0]     addend;
   logic [SUM_W+1:0]     partial;

   always_comb begin
      case (lo_ff[1:0])
         2'd0:    addend = '0;
         2'd1:    addend = {2'b00, a_ff};
         2'd2:    addend = {1'b0, a_ff, 1'b0};
         2'd3:    addend = a3_ff;
         default: addend = '0;
      endcase
      partial = {2'b00, hi_ff} + addend;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      a3_in   = a3_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = a;
         a3_in   = {2'b00, a} + {1'b0, a, 1'b0};
         hi_in   = '0;
         lo_in   = MUL_B_W'(b);
      end else if (busy_ff) begin
         hi_in  = partial[SUM_W+1:2];
         lo_in  = {partial[1:0], lo_ff[MUL_B_W-1:2]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff  <= a_in;
      a3_ff <= a3_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done    = done_ff;
   assign product = PROD_W'({hi_ff, lo_ff});

endmodule

[rtl/swmsd_sqrt.sv]
// Bit-serial integer square root, one root bit per cycle.
module swmsd_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [swmsd_pkg::RAD_W-1:0]  radicand,
   output logic                         done,
   output logic [swmsd_pkg::ROOT_W-1:0] root
);
   import swmsd_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ROOT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RAD_W-1:0]      rad_ff, rad_in;
   logic [ROOT_W:0]       rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [ROOT_W+1:0]     rem_sh;
   logic [ROOT_W+1:0]     trial;
   logic [ROOT_W+1:0]     diff;

   always_comb begin
      rem_sh = {rem_ff[ROOT_W-1:0], rad_ff[RAD_W-1 -: 2]};
      trial  = {root_ff, 2'b01};
      diff   = rem_sh - trial;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         cnt_in = cnt_ff + 1'b1;
         if (rem_sh >= trial) begin
            rem_in  = diff[ROOT_W:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[ROOT_W:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (cnt_ff == ROOT_CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[rtl/sliding_window_mean_stddev.sv]
// Top level: sliding-window mean and population standard deviation.
// Each sample transaction replaces the oldest of WINDOW entries (all zero after reset) and
// yields one result transaction: the window mean and population standard deviation, each
// with 4 fractional bits, truncated. Running sum and sum of squares are kept in registers;
// the square terms come from two radix-4 serial multipliers and the deviation from a
// bit-serial square root. One sample is in flight at a time: a new sample is taken only
// after the previous result is loaded into the output register. The result sits in that
// output register, so the next sample is taken while it waits; a result only stalls if
// the previous one is still not taken when the next finishes.
module sliding_window_mean_stddev (
   input  logic        clock,
   input  logic        reset,
   swmsd_req_if.sink   req_if,
   swmsd_rsp_if.source rsp_if
);
   import swmsd_pkg::*;

   state_type state_ff, state_in;

   logic [LOG2N-1:0]  slot_ff, slot_in;
   logic [WINDOW-1:0] valid_ff, valid_in;
   logic              old_valid_ff, old_valid_in;
   logic [KEEP_W-1:0] new_ff, new_in;
   logic              neg_ff, neg_in;
   logic [SUM_W-1:0]  s_ff, s_in;
   logic [SQ_W-1:0]   q_ff, q_in;
   logic              out_valid_ff, out_valid_in;
   logic [MEAN_W-1:0] mean_ff, mean_in;
   logic [STD_W-1:0]  std_ff, std_in;

   logic              accept;
   logic              req_ready;
   logic              ram_we;
   logic              mul_start;
   logic              sqrt_start;
   logic              out_load;
   logic [KEEP_W-1:0] ram_rdata;
   logic [KEEP_W-1:0] old_val;
   logic [KEEP_W-1:0] mag;
   logic [KEEP_W:0]   pair_sum;
   logic [SUM_W-1:0]  s_next;
   logic              mul1_done;
   logic              mul2_done;
   logic [PROD_W-1:0] mul1_prod;
   logic [PROD_W-1:0] mul2_prod;
   logic [SQ_W-1:0]   p1;
   logic [DEV_W-1:0]  dev;
   logic              sqrt_done;
   logic [ROOT_W-1:0] root;
   logic [SUM_W+3:0]  s_scaled;
   logic [ROOT_W-1:0] std_full;

   assign accept = req_if.valid & req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_MUL;
         ST_MUL: begin
            if (mul1_done && mul2_done) begin
               state_in = ST_QUPD;
            end
         end
         ST_QUPD: state_in = ST_DEV;
         ST_DEV:  state_in = ST_ROOT;
         ST_ROOT: begin
            if (sqrt_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      ram_we     = 1'b0;
      mul_start  = 1'b0;
      sqrt_start = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_READ: begin
            ram_we    = 1'b1;
            mul_start = 1'b1;
         end
         ST_MUL:  ;
         ST_QUPD: ;
         ST_DEV:  sqrt_start = 1'b1;
         ST_ROOT: ;
         ST_DONE: out_load = !out_valid_ff || rsp_if.ready;
         default: ;
      endcase
   end

   swmsd_ram #(
      .WIDTH (KEEP_W),
      .DEPTH (WINDOW)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_ff),
      .wdata (new_ff),
      .raddr (slot_ff),
      .rdata (ram_rdata)
   );

   always_comb begin
      old_val  = old_valid_ff ? ram_rdata : '0;
      pair_sum = {1'b0, new_ff} + {1'b0, old_val};
      mag      = (new_ff < old_val) ? (old_val - new_ff) : (new_ff - old_val);
      s_next   = s_ff + SUM_W'(new_ff) - SUM_W'(old_val);
   end

   swmsd_mul u_mul_q (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (SUM_W'(mag)),
      .b       (SUM_W'(pair_sum)),
      .done    (mul1_done),
      .product (mul1_prod)
   );

   swmsd_mul u_mul_s (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (s_next),
      .b       (s_next),
      .done    (mul2_done),
      .product (mul2_prod)
   );

   assign p1  = mul1_prod[SQ_W-1:0];
   assign dev = {q_ff, {LOG2N{1'b0}}} - mul2_prod;

   swmsd_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({dev, 8'h00}),
      .done     (sqrt_done),
      .root     (root)
   );

   always_comb begin
      s_scaled = {s_ff, 4'h0} >> LOG2N;
      std_full = root >> LOG2N;
   end

   always_comb begin
      slot_in      = slot_ff;
      valid_in     = valid_ff;
      old_valid_in = old_valid_ff;
      new_in       = new_ff;
      neg_in       = neg_ff;
      s_in         = s_ff;
      q_in         = q_ff;
      out_valid_in = out_valid_ff;
      mean_in      = mean_ff;
      std_in       = std_ff;
      if (accept) begin
         new_in       = req_if.sample[KEEP_W-1:0];
         old_valid_in = valid_ff[slot_ff];
      end
      if (ram_we) begin
         valid_in[slot_ff] = 1'b1;
         slot_in           = slot_ff + 1'b1;
         s_in              = s_next;
         neg_in            = new_ff < old_val;
      end
      if (state_ff == ST_QUPD) begin
         q_in = neg_ff ? (q_ff - p1) : (q_ff + p1);
      end
      if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
         mean_in      = MEAN_W'(s_scaled);
         std_in       = STD_W'(std_full);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         valid_ff     <= '0;
         s_ff         <= '0;
         q_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         valid_ff     <= valid_in;
         s_ff         <= s_in;
         q_ff         <= q_in;
         out_valid_ff <= out_valid_in;
      end
      old_valid_ff <= old_valid_in;
      new_ff       <= new_in;
      neg_ff       <= neg_in;
      mean_ff      <= mean_in;
      std_ff       <= std_in;
   end

   assign req_if.ready       = req_ready;
   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.window_mean = mean_ff;
   assign rsp_if.window_std  = std_ff;

endmodule
